// ===== src/kfci_pkg.sv =====
// Shared widths, constants and fixed-point helpers of the keyframe curve interpolator.
package kfci_pkg;

   localparam int KEY_W      = 8;
   localparam int MAX_KEYS   = 256;
   localparam int MAX_COMPS  = 4;
   localparam int QFRAC      = 16;
   localparam int DVD_W      = 56;
   localparam int DVS_W      = 40;
   localparam int DCNT_W     = 6;
   localparam int PROD_W     = 57;
   localparam int QPROD_W    = PROD_W - QFRAC;

   localparam logic signed [17:0] QONE = 18'sd65536;

   typedef logic signed [DVD_W-1:0] div_num_type;
   typedef logic signed [DVS_W-1:0] div_den_type;

   // Q16.16 product scaled back, truncated toward zero
   function automatic logic signed [QPROD_W-1:0] qtrunc(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + (p[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
      return t[PROD_W-1:QFRAC];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      if (v > 40'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

// ===== src/kfci_div.sv =====
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module kfci_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  kfci_pkg::div_num_type dividend,
   input  kfci_pkg::div_den_type divisor,
   output logic                 done,
   output kfci_pkg::div_num_type quotient
);

   localparam int NW = kfci_pkg::DVD_W;
   localparam int DW = kfci_pkg::DVS_W;

   logic          active_ff, active_in;
   logic          done_ff, done_in;
   logic [kfci_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW:0]   rem_sh;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      rem_sh    = {rem_ff, num_ff[NW-1]};
      if (start) begin
         active_in = 1'b1;
         cnt_in    = kfci_pkg::DCNT_W'(NW);
         neg_in    = dividend[NW-1] ^ divisor[DW-1];
         num_in    = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
         den_in    = divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
         rem_in    = '0;
      end else if (active_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = DW'(rem_sh - {1'b0, den_ff});
            num_in = {num_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DW-1:0];
            num_in = {num_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == kfci_pkg::DCNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      neg_ff <= neg_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(num_ff) : $signed(num_ff);

endmodule

// ===== src/keyframe_curve_interpolator.sv =====
// Top level of the keyframe curve interpolator: key tables, sequencer and shared multiplier.
//
// Channels: req_ takes items (tuser 0 loads one key table word, tuser 1 evaluates at
// a sample time); rsp_ returns one result per evaluate; csr_ writes the four registers
// (key_count, component_count, time_curve_mode, value_curve_mode) and is always ready.
// A load gives no result. An evaluate runs on one sequencer with a single 37x20
// multiplier and a divider: the end checks, one key tried at a time in the segment
// search, the linear fraction, the Newton steps (three steps), the Bernstein weights
// and then each value component in turn.
// req_tready is high only while the sequencer is idle. The result waits in an output
// register; the next item is accepted while it waits, and the sequencer holds at the
// end of the following evaluate until rsp_tready drains the register.
// Reset clears the registers to key_count 1, component_count 3, both modes 0, and the
// search start to key 0; the tables are undefined until written.
module keyframe_curve_interpolator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // key_index, word_select, word_data, sample_time, zeros
   input  logic         req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // value_x, value_y, value_z, value_w, segment
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [8:0]   csr_data
);

   localparam logic [1:0] REG_KEYS = 2'd0;
   localparam logic [1:0] REG_COMP = 2'd1;
   localparam logic [1:0] REG_TMOD = 2'd2;
   localparam logic [1:0] REG_VMOD = 2'd3;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_END0 = 5'd1;
   localparam logic [4:0] ST_END1 = 5'd2;
   localparam logic [4:0] ST_END2 = 5'd3;
   localparam logic [4:0] ST_SRA  = 5'd4;
   localparam logic [4:0] ST_SRB  = 5'd5;
   localparam logic [4:0] ST_SRC  = 5'd6;
   localparam logic [4:0] ST_TF0  = 5'd7;
   localparam logic [4:0] ST_TF1  = 5'd8;
   localparam logic [4:0] ST_TF2  = 5'd9;
   localparam logic [4:0] ST_LDIV = 5'd10;
   localparam logic [4:0] ST_TC0  = 5'd11;
   localparam logic [4:0] ST_TC1  = 5'd12;
   localparam logic [4:0] ST_TC2  = 5'd13;
   localparam logic [4:0] ST_MUL  = 5'd14;
   localparam logic [4:0] ST_NDIV = 5'd15;
   localparam logic [4:0] ST_NWT  = 5'd16;
   localparam logic [4:0] ST_VPRE = 5'd17;
   localparam logic [4:0] ST_VA   = 5'd18;
   localparam logic [4:0] ST_VB   = 5'd19;
   localparam logic [4:0] ST_VC   = 5'd20;
   localparam logic [4:0] ST_VD   = 5'd21;
   localparam logic [4:0] ST_VE   = 5'd22;
   localparam logic [4:0] ST_VSAT = 5'd23;
   localparam logic [4:0] ST_DONE = 5'd24;

   localparam logic [4:0] OP_N_SS  = 5'd0;
   localparam logic [4:0] OP_N_S2S = 5'd1;
   localparam logic [4:0] OP_N_AS3 = 5'd2;
   localparam logic [4:0] OP_N_BS2 = 5'd3;
   localparam logic [4:0] OP_N_AS2 = 5'd4;
   localparam logic [4:0] OP_N_CS  = 5'd5;
   localparam logic [4:0] OP_N_BS  = 5'd6;
   localparam logic [4:0] OP_B_SS  = 5'd7;
   localparam logic [4:0] OP_B_S2S = 5'd8;
   localparam logic [4:0] OP_B_UU  = 5'd9;
   localparam logic [4:0] OP_B_U2U = 5'd10;
   localparam logic [4:0] OP_B_SU2 = 5'd11;
   localparam logic [4:0] OP_B_S2U = 5'd12;
   localparam logic [4:0] OP_V_LIN = 5'd13;
   localparam logic [4:0] OP_V_U3  = 5'd14;
   localparam logic [4:0] OP_V_B1  = 5'd15;
   localparam logic [4:0] OP_V_B2  = 5'd16;
   localparam logic [4:0] OP_V_S3  = 5'd17;

   localparam int TDEPTH = 3 * kfci_pkg::MAX_KEYS;
   localparam int VDEPTH = 3 * kfci_pkg::MAX_COMPS * kfci_pkg::MAX_KEYS;

   // configuration
   logic [8:0] key_count_ff;
   logic [2:0] comp_count_ff;
   logic [1:0] tmode_ff;
   logic       vmode_ff;

   // request fields
   logic [7:0]         req_key;
   logic [3:0]         req_ws;
   logic [3:0]         req_wsm;
   logic signed [31:0] req_word;
   logic signed [31:0] req_time;
   logic               req_acc;

   // control
   logic [4:0] state_ff, state_in;
   logic [4:0] op_ff, op_in;
   logic       phase_ff, phase_in;
   logic [1:0] iter_ff, iter_in;
   logic [7:0] sstart_ff, sstart_in;
   logic [7:0] a_ff, a_in;
   logic [8:0] i_ff, i_in;
   logic [1:0] comp_ff, comp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // payload
   logic [7:0]         k_ff, k_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] ta_ff, ta_in;
   logic signed [31:0] t1_ff, t1_in;
   logic signed [31:0] t2_ff, t2_in;
   logic signed [31:0] c1_ff, c1_in;
   logic signed [36:0] ca_ff, ca_in;
   logic signed [36:0] cb_ff, cb_in;
   logic signed [36:0] cc_ff, cc_in;
   logic signed [17:0] s_ff, s_in;
   logic signed [17:0] s2_ff, s2_in;
   logic signed [17:0] s3_ff, s3_in;
   logic signed [17:0] u_ff, u_in;
   logic signed [17:0] u2_ff, u2_in;
   logic signed [17:0] u3_ff, u3_in;
   logic signed [19:0] b1_ff, b1_in;
   logic signed [19:0] b2_ff, b2_in;
   logic signed [39:0] f_ff, f_in;
   logic signed [39:0] d_ff, d_in;
   logic signed [39:0] acc_ff, acc_in;
   logic signed [31:0] v0_ff, v0_in;
   logic signed [31:0] v1_ff, v1_in;
   logic signed [31:0] p1_ff, p1_in;
   logic signed [31:0] p2_ff, p2_in;
   logic signed [31:0] res_ff [kfci_pkg::MAX_COMPS];
   logic [135:0]       rsp_data_ff, rsp_data_in;
   logic signed [kfci_pkg::PROD_W-1:0] prod_ff, prod_in;

   // memories
   logic [31:0] time_mem [TDEPTH];
   logic [31:0] val_mem  [VDEPTH];
   logic [31:0] time_rd_ff;
   logic [31:0] val_rd_ff;
   logic [7:0]  tkey;
   logic [1:0]  tword;
   logic [9:0]  taddr;
   logic        time_we;
   logic [7:0]  vkey;
   logic [1:0]  vgrp;
   logic [1:0]  vcomp;
   logic [9:0]  vrow;
   logic [11:0] vaddr;
   logic        val_we;

   // derived
   logic [8:0]         n;
   logic [7:0]         nm1;
   logic [2:0]         nc;
   logic [7:0]         k1;
   logic signed [31:0] trd;
   logic signed [31:0] vrd;
   logic signed [36:0] mul_a;
   logic signed [19:0] mul_b;
   logic signed [kfci_pkg::QPROD_W-1:0] q;
   logic signed [39:0] q40;
   logic               store_en;
   logic signed [31:0] store_val;
   logic signed [32:0] dx;
   logic signed [57:0] s_next;

   logic                  div_start;
   kfci_pkg::div_num_type div_num;
   kfci_pkg::div_den_type div_den;
   logic                  div_done;
   kfci_pkg::div_num_type div_q;

   kfci_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_key  = req_tdata[7:0];
   assign req_ws   = req_tdata[11:8];
   assign req_wsm  = req_ws - 4'd3;
   assign req_word = req_tdata[43:12];
   assign req_time = req_tdata[75:44];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc  = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign n = (key_count_ff == 9'd0) ? 9'd1 :
              (key_count_ff > 9'(kfci_pkg::MAX_KEYS)) ? 9'(kfci_pkg::MAX_KEYS) : key_count_ff;
   assign nm1 = 8'(n - 9'd1);
   assign nc = (comp_count_ff == 3'd0) ? 3'd1 :
               (comp_count_ff > 3'(kfci_pkg::MAX_COMPS)) ? 3'(kfci_pkg::MAX_COMPS)
                                                         : comp_count_ff;
   assign k1  = (k_ff < nm1) ? k_ff + 8'd1 : k_ff;
   assign trd = time_rd_ff;
   assign vrd = val_rd_ff;

   // table addressing
   always_comb begin
      tkey  = '0;
      tword = '0;
      vkey  = '0;
      vgrp  = '0;
      vcomp = comp_ff;
      case (state_ff)
         ST_IDLE: begin
            tkey  = req_key;
            tword = req_ws[1:0];
            vkey  = req_key;
            vgrp  = req_wsm[3:2];
            vcomp = req_wsm[1:0];
         end
         ST_END1: tkey = nm1;
         ST_SRA:  tkey = a_ff;
         ST_SRB:  tkey = a_ff + 8'd1;
         ST_TF0:  tkey = k_ff;
         ST_TF1:  tkey = k1;
         ST_TC0: begin
            tkey  = k_ff;
            tword = 2'd2;
         end
         ST_TC1: begin
            tkey  = k1;
            tword = 2'd1;
         end
         ST_VA:   vkey = k_ff;
         ST_VB:   vkey = k1;
         ST_VC: begin
            vkey = k_ff;
            vgrp = 2'd2;
         end
         ST_VD: begin
            vkey = k1;
            vgrp = 2'd1;
         end
         default: begin
         end
      endcase
   end

   assign taddr = {1'b0, tkey, 1'b0} + {2'b00, tkey} + {8'd0, tword};
   assign vrow  = {1'b0, vkey, 1'b0} + {2'b00, vkey} + {8'd0, vgrp};
   assign vaddr = {vrow, vcomp};
   assign time_we = req_acc & ~req_tuser & (req_ws <= 4'd2);
   assign val_we  = req_acc & ~req_tuser & (req_ws >= 4'd3) & (req_ws <= 4'd14);

   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[taddr] <= req_word;
      end
      time_rd_ff <= time_mem[taddr];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[vaddr] <= req_word;
      end
      val_rd_ff <= val_mem[vaddr];
   end

   // shared multiplier operands
   always_comb begin
      mul_a = 37'(s_ff);
      mul_b = 20'(s_ff);
      case (op_ff)
         OP_N_SS, OP_B_SS: begin
            mul_a = 37'(s_ff);
            mul_b = 20'(s_ff);
         end
         OP_N_S2S, OP_B_S2S: begin
            mul_a = 37'(s2_ff);
            mul_b = 20'(s_ff);
         end
         OP_N_AS3: begin
            mul_a = ca_ff;
            mul_b = 20'(s3_ff);
         end
         OP_N_BS2: begin
            mul_a = cb_ff;
            mul_b = 20'(s2_ff);
         end
         OP_N_AS2: begin
            mul_a = ca_ff;
            mul_b = 20'(s2_ff);
         end
         OP_N_CS: begin
            mul_a = cc_ff;
            mul_b = 20'(s_ff);
         end
         OP_N_BS: begin
            mul_a = cb_ff;
            mul_b = 20'(s_ff);
         end
         OP_B_UU: begin
            mul_a = 37'(u_ff);
            mul_b = 20'(u_ff);
         end
         OP_B_U2U: begin
            mul_a = 37'(u2_ff);
            mul_b = 20'(u_ff);
         end
         OP_B_SU2: begin
            mul_a = 37'(u2_ff);
            mul_b = 20'(s_ff);
         end
         OP_B_S2U: begin
            mul_a = 37'(s2_ff);
            mul_b = 20'(u_ff);
         end
         OP_V_LIN: begin
            mul_a = 37'(v1_ff) - 37'(v0_ff);
            mul_b = 20'(s_ff);
         end
         OP_V_U3: begin
            mul_a = 37'(v0_ff);
            mul_b = 20'(u3_ff);
         end
         OP_V_B1: begin
            mul_a = 37'(p1_ff);
            mul_b = b1_ff;
         end
         OP_V_B2: begin
            mul_a = 37'(p2_ff);
            mul_b = b2_ff;
         end
         OP_V_S3: begin
            mul_a = 37'(v1_ff);
            mul_b = 20'(s3_ff);
         end
         default: begin
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign q       = kfci_pkg::qtrunc(prod_ff);
   assign q40     = q[39:0];
   assign dx      = 33'(x_ff) - 33'(t1_ff);
   assign s_next  = 58'(s_ff) - 58'(div_q);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      phase_in  = phase_ff;
      iter_in   = iter_ff;
      sstart_in = sstart_ff;
      a_in      = a_ff;
      i_in      = i_ff;
      comp_in   = comp_ff;
      k_in      = k_ff;
      x_in      = x_ff;
      ta_in     = ta_ff;
      t1_in     = t1_ff;
      t2_in     = t2_ff;
      c1_in     = c1_ff;
      ca_in     = ca_ff;
      cb_in     = cb_ff;
      cc_in     = cc_ff;
      s_in      = s_ff;
      s2_in     = s2_ff;
      s3_in     = s3_ff;
      u_in      = u_ff;
      u2_in     = u2_ff;
      u3_in     = u3_ff;
      b1_in     = b1_ff;
      b2_in     = b2_ff;
      f_in      = f_ff;
      d_in      = d_ff;
      acc_in    = acc_ff;
      v0_in     = v0_ff;
      v1_in     = v1_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      store_en  = 1'b0;
      store_val = '0;
      div_start = 1'b0;
      div_num   = 56'(dx) <<< 16;
      div_den   = 40'(t2_ff) - 40'(t1_ff);
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tuser) begin
               x_in     = req_time;
               state_in = ST_END0;
            end
         end
         ST_END0: state_in = ST_END1;
         ST_END1: begin
            ta_in    = trd;
            state_in = ST_END2;
         end
         ST_END2: begin
            if (x_ff <= ta_ff) begin
               k_in     = 8'd0;
               state_in = ST_TF0;
            end else if (x_ff >= trd) begin
               k_in     = nm1;
               state_in = ST_TF0;
            end else begin
               a_in     = (sstart_ff >= nm1) ? 8'd0 : sstart_ff;
               i_in     = 9'd0;
               state_in = ST_SRA;
            end
         end
         ST_SRA: state_in = ST_SRB;
         ST_SRB: begin
            ta_in    = trd;
            state_in = ST_SRC;
         end
         ST_SRC: begin
            if (a_ff < nm1 && ta_ff <= x_ff && x_ff <= trd) begin
               k_in      = a_ff;
               sstart_in = a_ff;
               state_in  = ST_TF0;
            end else begin
               a_in = ({1'b0, a_ff} + 9'd1 == n) ? 8'd0 : a_ff + 8'd1;
               i_in = i_ff + 9'd1;
               if (i_ff + 9'd1 == n) begin
                  k_in     = nm1;
                  state_in = ST_TF0;
               end else begin
                  state_in = ST_SRA;
               end
            end
         end
         ST_TF0: begin
            if (tmode_ff[1]) begin
               s_in     = '0;
               state_in = ST_VPRE;
            end else if (k_ff >= nm1) begin
               s_in     = kfci_pkg::QONE;
               state_in = ST_VPRE;
            end else begin
               state_in = ST_TF1;
            end
         end
         ST_TF1: begin
            t1_in    = trd;
            state_in = ST_TF2;
         end
         ST_TF2: begin
            t2_in = trd;
            if (x_ff <= t1_ff) begin
               s_in     = '0;
               state_in = ST_VPRE;
            end else if (x_ff >= trd) begin
               s_in     = kfci_pkg::QONE;
               state_in = ST_VPRE;
            end else begin
               div_start = 1'b1;
               div_den   = 40'(trd) - 40'(t1_ff);
               state_in  = ST_LDIV;
            end
         end
         ST_LDIV: begin
            if (div_done) begin
               s_in     = div_q[17:0];
               state_in = tmode_ff[0] ? ST_TC0 : ST_VPRE;
            end
         end
         ST_TC0: state_in = ST_TC1;
         ST_TC1: begin
            c1_in    = trd;
            state_in = ST_TC2;
         end
         ST_TC2: begin
            ca_in    = 37'(t2_ff) - 37'(trd) * 37'sd3 + 37'(c1_ff) * 37'sd3 - 37'(t1_ff);
            cb_in    = 37'(trd) - 37'(c1_ff) * 37'sd2 + 37'(t1_ff);
            cc_in    = 37'(c1_ff) - 37'(t1_ff);
            iter_in  = 2'd0;
            op_in    = OP_N_SS;
            phase_in = 1'b0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               op_in    = op_ff + 5'd1;
               case (op_ff)
                  OP_N_SS, OP_B_SS:   s2_in = q[17:0];
                  OP_N_S2S, OP_B_S2S: s3_in = q[17:0];
                  OP_N_AS3: f_in = q40;
                  OP_N_BS2: f_in = f_ff + q40 * 40'sd3;
                  OP_N_AS2: d_in = q40 * 40'sd3;
                  OP_N_CS:  f_in = f_ff + q40 * 40'sd3;
                  OP_N_BS: begin
                     d_in     = d_ff + q40 * 40'sd6 + 40'(cc_ff) * 40'sd3;
                     f_in     = f_ff + 40'(t1_ff) - 40'(x_ff);
                     state_in = ST_NDIV;
                  end
                  OP_B_UU:  u2_in = q[17:0];
                  OP_B_U2U: u3_in = q[17:0];
                  OP_B_SU2: b1_in = 20'(q40 * 40'sd3);
                  OP_B_S2U: begin
                     b2_in    = 20'(q40 * 40'sd3);
                     state_in = ST_VA;
                  end
                  OP_V_LIN: begin
                     acc_in   = 40'(v0_ff) + q40;
                     state_in = ST_VSAT;
                  end
                  OP_V_U3: acc_in = q40;
                  OP_V_B1, OP_V_B2: acc_in = acc_ff + q40;
                  OP_V_S3: begin
                     acc_in   = acc_ff + q40;
                     state_in = ST_VSAT;
                  end
                  default: state_in = ST_VSAT;
               endcase
            end
         end
         ST_NDIV: begin
            if (d_ff == 40'sd0) begin
               iter_in  = iter_ff + 2'd1;
               op_in    = OP_N_SS;
               state_in = (iter_ff == 2'd2) ? ST_VPRE : ST_MUL;
            end else begin
               div_start = 1'b1;
               div_num   = {f_ff, 16'd0};
               div_den   = d_ff;
               state_in  = ST_NWT;
            end
         end
         ST_NWT: begin
            if (div_done) begin
               if (s_next < 58'sd0) begin
                  s_in = '0;
               end else if (s_next > 58'(kfci_pkg::QONE)) begin
                  s_in = kfci_pkg::QONE;
               end else begin
                  s_in = s_next[17:0];
               end
               iter_in  = iter_ff + 2'd1;
               op_in    = OP_N_SS;
               state_in = (iter_ff == 2'd2) ? ST_VPRE : ST_MUL;
            end
         end
         ST_VPRE: begin
            comp_in = 2'd0;
            if (vmode_ff && k_ff < nm1 && s_ff > 18'sd0 && s_ff < kfci_pkg::QONE) begin
               u_in     = kfci_pkg::QONE - s_ff;
               op_in    = OP_B_SS;
               phase_in = 1'b0;
               state_in = ST_MUL;
            end else begin
               state_in = ST_VA;
            end
         end
         ST_VA: begin
            if ({1'b0, comp_ff} >= nc) begin
               store_en = 1'b1;
            end else begin
               state_in = ST_VB;
            end
         end
         ST_VB: begin
            v0_in    = vrd;
            state_in = ST_VC;
         end
         ST_VC: begin
            v1_in    = vrd;
            state_in = ST_VD;
         end
         ST_VD: begin
            p1_in    = vrd;
            state_in = ST_VE;
         end
         ST_VE: begin
            p2_in = vrd;
            if (k_ff >= nm1 || s_ff <= 18'sd0) begin
               store_en  = 1'b1;
               store_val = v0_ff;
            end else if (s_ff >= kfci_pkg::QONE) begin
               store_en  = 1'b1;
               store_val = v1_ff;
            end else begin
               op_in    = vmode_ff ? OP_V_U3 : OP_V_LIN;
               phase_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_VSAT: begin
            store_en  = 1'b1;
            store_val = kfci_pkg::sat32(acc_ff);
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {k_ff, res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (store_en) begin
         comp_in  = comp_ff + 2'd1;
         state_in = (comp_ff == 2'd3) ? ST_DONE : ST_VA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff  <= 9'd1;
         comp_count_ff <= 3'd3;
         tmode_ff      <= 2'd0;
         vmode_ff      <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_KEYS: key_count_ff  <= csr_data;
            REG_COMP: comp_count_ff <= csr_data[2:0];
            REG_TMOD: tmode_ff      <= csr_data[1:0];
            REG_VMOD: vmode_ff      <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_N_SS;
         phase_ff     <= 1'b0;
         iter_ff      <= 2'd0;
         sstart_ff    <= 8'd0;
         a_ff         <= 8'd0;
         i_ff         <= 9'd0;
         comp_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         iter_ff      <= iter_in;
         sstart_ff    <= sstart_in;
         a_ff         <= a_in;
         i_ff         <= i_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      x_ff        <= x_in;
      ta_ff       <= ta_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      c1_ff       <= c1_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      cc_ff       <= cc_in;
      s_ff        <= s_in;
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      u_ff        <= u_in;
      u2_ff       <= u2_in;
      u3_ff       <= u3_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      f_ff        <= f_in;
      d_ff        <= d_in;
      acc_ff      <= acc_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      if (store_en) begin
         res_ff[comp_ff] <= store_val;
      end
   end

endmodule

// ===== tb/keyframe_curve_interpolator_checker.sv =====
// Checker of the keyframe curve interpolator: watches the channels, predicts each result and compares.
module keyframe_curve_interpolator_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [79:0]  req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [135:0] rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [8:0]   csr_data,
   output int           fail_count,
   output int           pending
);
   import kfci_pkg::*;

   localparam logic [1:0] REG_KEYS = 2'd0, REG_COMPS = 2'd1, REG_TMODE = 2'd2, REG_VMODE = 2'd3;
   localparam longint ONE = 65536;

   typedef struct packed {
      logic [31:0] x, y, z, w;
      logic [7:0]  seg;
   } sample_t;

   logic [8:0] key_count;
   logic [2:0] comp_count;
   logic [1:0] time_mode;
   logic       value_mode;
   logic signed [31:0] time_words [0:3*MAX_KEYS-1];
   logic signed [31:0] value_words [0:3*MAX_COMPS*MAX_KEYS-1];
   logic [7:0] search_from;
   sample_t    expected_q[$];

   function automatic longint qm(longint a, longint b);
      return (a * b) / ONE;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint kt(int k, int w);
      return longint'(time_words[3*k+w]);
   endfunction

   function automatic longint kv(int k, int g, int c);
      return longint'(value_words[k*3*MAX_COMPS + g*MAX_COMPS + c]);
   endfunction

   function automatic sample_t interpolate(logic signed [31:0] xin);
      sample_t r;
      int n, nc, k, a, c;
      longint x, s, t1, t2, c1, c2, ca, cb, cc, s2, s3, f, d, u, u2, u3, b1, b2, v, v0, v1;
      logic found;
      n = (key_count == 0) ? 1 : (key_count > MAX_KEYS) ? MAX_KEYS : int'(key_count);
      nc = (comp_count == 0) ? 1 : (comp_count > MAX_COMPS) ? MAX_COMPS : int'(comp_count);
      x = longint'(xin);
      if (x <= kt(0, 0)) k = 0;
      else if (x >= kt(n-1, 0)) k = n - 1;
      else begin
         a = search_from;
         if (a >= n - 1) a = 0;
         k = n - 1;
         found = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (!found && a < n - 1 && kt(a, 0) <= x && x <= kt(a+1, 0)) begin
               search_from = a[7:0];
               k = a;
               found = 1'b1;
            end
            a = (a + 1 == n) ? 0 : a + 1;
         end
      end
      // fraction along the segment
      if (time_mode > 1) s = 0;
      else if (k >= n - 1) s = ONE;
      else begin
         t1 = kt(k, 0);
         t2 = kt(k+1, 0);
         if (x <= t1) s = 0;
         else if (x >= t2) s = ONE;
         else begin
            s = ((x - t1) * ONE) / (t2 - t1);
            if (time_mode == 1) begin
               c1 = kt(k, 2);
               c2 = kt(k+1, 1);
               ca = t2 - 3*c2 + 3*c1 - t1;
               cb = c2 - 2*c1 + t1;
               cc = c1 - t1;
               for (int it = 0; it < 3; it++) begin
                  s2 = qm(s, s);
                  s3 = qm(s2, s);
                  f = qm(ca, s3) + 3*qm(cb, s2) + 3*qm(cc, s) + t1 - x;
                  d = 3*qm(ca, s2) + 6*qm(cb, s) + 3*cc;
                  if (d != 0) begin
                     s -= (f * ONE) / d;
                     if (s < 0) s = 0;
                     if (s > ONE) s = ONE;
                  end
               end
            end
         end
      end
      r = '0;
      for (c = 0; c < 4; c++) begin
         v = 0;
         if (c < nc) begin
            if (k >= n - 1) v = kv(n-1, 0, c);
            else if (s <= 0) v = kv(k, 0, c);
            else if (s >= ONE) v = kv(k+1, 0, c);
            else begin
               v0 = kv(k, 0, c);
               v1 = kv(k+1, 0, c);
               if (value_mode == 1'b0) v = v0 + qm(s, v1 - v0);
               else begin
                  u = ONE - s;
                  s2 = qm(s, s);
                  s3 = qm(s2, s);
                  u2 = qm(u, u);
                  u3 = qm(u2, u);
                  b1 = 3*qm(s, u2);
                  b2 = 3*qm(s2, u);
                  v = qm(u3, v0) + qm(b1, kv(k, 2, c)) + qm(b2, kv(k+1, 1, c)) + qm(s3, v1);
               end
               v = clip32(v);
            end
         end
         case (c)
            0: r.x = v[31:0];
            1: r.y = v[31:0];
            2: r.z = v[31:0];
            default: r.w = v[31:0];
         endcase
      end
      r.seg = k[7:0];
      return r;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      sample_t got, want;
      logic [3:0] ws;
      if (reset) begin
         key_count   <= 9'd1;
         comp_count  <= 3'd3;
         time_mode   <= 2'd0;
         value_mode  <= 1'b0;
         search_from <= 8'd0;
         fail_count  <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_KEYS:  key_count  <= csr_data;
               REG_COMPS: comp_count <= csr_data[2:0];
               REG_TMODE: time_mode  <= csr_data[1:0];
               REG_VMODE: value_mode <= csr_data[0];
            endcase
         end
         if (req_tvalid && req_tready) begin
            ws = req_tdata[11:8];
            if (req_tuser == 1'b0) begin
               if (ws <= 4'd2) time_words[3*req_tdata[7:0] + ws] = req_tdata[43:12];
               else if (ws <= 4'd14)
                  value_words[req_tdata[7:0]*3*MAX_COMPS + ((ws-3)/4)*MAX_COMPS + (ws-3)%4]
                     = req_tdata[43:12];
            end else expected_q.push_back(interpolate(req_tdata[75:44]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_q.size() == 0) begin
               $error("result with no expectation: %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got.x !== want.x) $error("value_x expected %0d got %0d",
                  $signed(want.x), $signed(got.x));
               if (got.y !== want.y) $error("value_y expected %0d got %0d",
                  $signed(want.y), $signed(got.y));
               if (got.z !== want.z) $error("value_z expected %0d got %0d",
                  $signed(want.z), $signed(got.z));
               if (got.w !== want.w) $error("value_w expected %0d got %0d",
                  $signed(want.w), $signed(got.w));
               if (got.seg !== want.seg) $error("segment expected %0d got %0d",
                  want.seg, got.seg);
               if (got !== want) fail_count <= fail_count + 1;
            end
         end
      end
   end

   // sample_t packs x in the top bits and segment in the lowest; the bench reorders the port data to match
   initial begin
      if ($bits(sample_t) != 136) $error("sample layout");
   end
endmodule

// ===== tb/keyframe_curve_interpolator_tb.sv =====
// Testbench top of the keyframe curve interpolator: stimulus, stalls and verdict.
module keyframe_curve_interpolator_tb;
   import kfci_pkg::*;

   localparam logic [1:0] REG_KEYS = 2'd0, REG_COMPS = 2'd1, REG_TMODE = 2'd2, REG_VMODE = 2'd3;
   localparam logic KIND_LOAD = 1'b0, KIND_EVAL = 1'b1;
   localparam logic [3:0] WS_TIME = 4'd0, WS_TIN = 4'd1, WS_TOUT = 4'd2, WS_VAL = 4'd3,
      WS_VIN = 4'd7, WS_VOUT = 4'd11, WS_BAD = 4'd15;
   localparam longint LIMIT = 6000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0, req_tready, req_tuser = 1'b0;
   logic [79:0]  req_tdata = '0;
   logic         rsp_tvalid, rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         csr_valid = 1'b0, csr_ready;
   logic [1:0]   csr_index = '0;
   logic [8:0]   csr_data = '0;
   int           fail_count, pending;
   longint       cycles = 0;
   logic signed [31:0] key_times [0:MAX_KEYS-1];
   int           keys_now = 1;
   int           stall_mode = 0;
   logic [135:0] rsp_swapped;

   // port layout: x lowest, segment highest; checker struct has x highest
   assign rsp_swapped = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                         rsp_tdata[127:96], rsp_tdata[135:128]};

   keyframe_curve_interpolator dut (.*);

   keyframe_curve_interpolator_checker chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata(rsp_swapped),
      .csr_valid, .csr_ready, .csr_index, .csr_data, .fail_count, .pending);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("keyframe_curve_interpolator_tb failed");
         $finish;
      end
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= $urandom_range(0, 1);
      endcase
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic send(logic kind, logic [7:0] key, logic [3:0] ws, logic [31:0] data,
                       logic [31:0] xt, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'd0, xt, data, ws, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == KIND_LOAD && ws == WS_TIME) key_times[key] = data;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic configure(int kc, int cc, int tm, int vm);
      drain();
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= i[1:0];
         csr_data  <= (i == 0) ? kc[8:0] : (i == 1) ? cc[8:0] : (i == 2) ? tm[8:0] : vm[8:0];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      keys_now = (kc == 0) ? 1 : (kc > MAX_KEYS) ? MAX_KEYS : kc;
   endtask

   function automatic logic [31:0] value_word();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom_range(0, 20 * 65536) - 10 * 65536;
      endcase
   endfunction

   task automatic load_key(int k, logic signed [31:0] t, int gap);
      send(KIND_LOAD, k[7:0], WS_TIME, t, $urandom(), gap);
      send(KIND_LOAD, k[7:0], WS_TIN, t - $urandom_range(0, 3 * 65536), $urandom(), gap);
      send(KIND_LOAD, k[7:0], WS_TOUT, t + $urandom_range(0, 3 * 65536), $urandom(), gap);
      for (int g = 0; g < 3; g++)
         for (int c = 0; c < 4; c++)
            send(KIND_LOAD, k[7:0], WS_VAL + 4 * g + c, value_word(), $urandom(), gap);
   endtask

   function automatic logic [31:0] pick_time();
      int k;
      longint lo, hi;
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         2: return key_times[$urandom_range(0, keys_now - 1)];
         default: begin
            if (keys_now < 2) return key_times[0] + $urandom_range(0, 65536) - 32768;
            k = $urandom_range(0, keys_now - 2);
            lo = longint'(key_times[k]);
            hi = longint'(key_times[k+1]);
            if (hi <= lo) return key_times[k];
            return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
         end
      endcase
   endfunction

   task automatic eval_at(logic [31:0] xt, int gap);
      send(KIND_EVAL, $urandom(), $urandom(), $urandom(), xt, gap);
   endtask

   initial begin
      int kc;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // fill the whole table with ascending key times
      for (int k = 0; k < MAX_KEYS; k++)
         load_key(k, k * 4 * 65536 + $urandom_range(0, 65535) - 8 * 65536,
                  $urandom_range(0, 9) == 0 ? gap_len() : 0);
      // directed
      eval_at(pick_time(), 0);
      configure(2, 3, 0, 0);
      eval_at(32'h80000000, 0);
      eval_at(32'h7fffffff, 1);
      eval_at(key_times[0], 0);
      eval_at(key_times[1], 0);
      eval_at(pick_time(), 0);
      configure(0, 0, 3, 1);
      eval_at(pick_time(), 0);
      configure(511, 7, 1, 1);
      eval_at(pick_time(), 0);
      eval_at(key_times[200] + 100, 0);
      eval_at(key_times[10] + 100, 0);
      configure(256, 4, 2, 0);
      eval_at(pick_time(), 0);
      eval_at(key_times[255], 0);
      configure(4, 4, 1, 1);
      send(KIND_LOAD, 8'd1, WS_BAD, $urandom(), $urandom(), 0);
      send(KIND_LOAD, 8'd2, WS_TOUT, key_times[2], $urandom(), 0);
      send(KIND_LOAD, 8'd3, WS_TIN, key_times[3], $urandom(), 0);
      eval_at(key_times[2] + 4000, 0);
      send(KIND_LOAD, 8'd1, WS_TIME, key_times[3] + 65536, $urandom(), 0);
      eval_at(key_times[2] + 100, 0);
      eval_at(key_times[1] - 100, 0);
      send(KIND_LOAD, 8'd1, WS_TIME, key_times[0] + 4 * 65536, $urandom(), 0);
      // random phases
      for (int p = 0; p < 14; p++) begin
         kc = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 16);
         configure(kc, $urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 1));
         for (int i = 0; i < 50; i++) begin
            case ($urandom_range(0, 19))
               0: send(KIND_LOAD, $urandom(), $urandom(), $urandom(), $urandom(), gap_len());
               1, 2: send(KIND_LOAD, $urandom_range(0, keys_now - 1),
                          WS_VAL + $urandom_range(0, 11), value_word(), $urandom(), gap_len());
               3: send(KIND_LOAD, $urandom_range(0, keys_now - 1), $urandom_range(1, 2),
                       key_times[$urandom_range(0, keys_now - 1)] + $urandom_range(0, 65536),
                       $urandom(), gap_len());
               default: eval_at(pick_time(), gap_len());
            endcase
         end
      end
      drain();
      repeat (1200) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("keyframe_curve_interpolator_tb passed");
      end else begin
         $display("keyframe_curve_interpolator_tb failed");
      end
      $finish;
   end
endmodule
